### design/spsg_pkg.sv
// Shared types and constants for the stereo tone and noise sound generator.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package spsg_pkg;

    // Field widths.
    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int SEL_W    = 3;
    localparam int PITCH_W  = 10;
    localparam int ATTEN_W  = 4;
    localparam int LFSR_W   = 15;
    localparam int RATE_W   = 2;
    localparam int NUM_TONE = 3;
    localparam int NUM_CHAN = 4;

    // Operation codes carried on the input tuser.
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_LEFT  = 2'd1;
    localparam logic [OP_W-1:0] OP_RIGHT = 2'd2;

    // Channel numbers inside the register select.
    localparam logic [1:0] CH_TONE_C = 2'd2;
    localparam logic [1:0] CH_NOISE  = 2'd3;

    // Noise divider reload values for the fixed rates.
    localparam logic [PITCH_W-1:0] NOISE_RELOAD_0 = 10'h010;
    localparam logic [PITCH_W-1:0] NOISE_RELOAD_1 = 10'h020;
    localparam logic [PITCH_W-1:0] NOISE_RELOAD_2 = 10'h040;

    // Rate select codes for the fixed rates.
    localparam logic [RATE_W-1:0] RATE_FAST = 2'd0;
    localparam logic [RATE_W-1:0] RATE_MID  = 2'd1;
    localparam logic [RATE_W-1:0] RATE_SLOW = 2'd2;

    // Rate select code that uses the programmed noise period.
    localparam logic [RATE_W-1:0] RATE_PERIOD = 2'd3;

    // Shift register value after a noise control write.
    localparam logic [LFSR_W-1:0] LFSR_SEED = 15'h4000;

    // Attenuation shown while a channel output is low.
    localparam logic [ATTEN_W-1:0] ATTEN_OFF = 4'hF;

    // Programmed settings handed from the register file to the generators.
    typedef struct packed {
        logic [NUM_TONE-1:0][PITCH_W-1:0] tone_period;
        logic [PITCH_W-1:0]               noise_period;
        logic [RATE_W-1:0]                noise_rate_sel;
        logic                             white_mode;
        logic                             lfsr_load;
    } spsg_cfg_t;

endpackage

`default_nettype wire

### design/spsg_regs.sv
// Port write decoder and register file: register select, pitches, attenuations
// and noise control. Depends on spsg_pkg.
`default_nettype none

module spsg_regs (
    input  wire logic                                          aclk,
    input  wire logic                                          aresetn,
    input  wire logic                                          wr_en,
    input  wire logic                                          wr_right,
    input  wire logic [spsg_pkg::BYTE_W-1:0]                   wr_data,
    output spsg_pkg::spsg_cfg_t                                cfg,
    output logic [spsg_pkg::NUM_CHAN-1:0][spsg_pkg::ATTEN_W-1:0] atten_left,
    output logic [spsg_pkg::NUM_CHAN-1:0][spsg_pkg::ATTEN_W-1:0] atten_right
);

    logic [spsg_pkg::SEL_W-1:0]                              sel_reg, sel_next;
    logic [spsg_pkg::NUM_TONE-1:0][spsg_pkg::PITCH_W-1:0]    tone_period_reg, tone_period_next;
    logic [spsg_pkg::NUM_CHAN-1:0][spsg_pkg::ATTEN_W-1:0]    atl_reg, atl_next;
    logic [spsg_pkg::NUM_CHAN-1:0][spsg_pkg::ATTEN_W-1:0]    atr_reg, atr_next;
    logic [spsg_pkg::PITCH_W-1:0]                            noise_period_reg, noise_period_next;
    logic [spsg_pkg::RATE_W-1:0]                             rate_reg, rate_next;
    logic                                                    white_reg, white_next;
    logic                                                    lfsr_load;
    logic                                                    latch;
    logic [1:0]                                              ch;

    // The latched select takes effect for the byte that carries it.
    assign latch    = wr_data[spsg_pkg::BYTE_W-1];
    assign sel_next = (wr_en && latch) ? wr_data[6:4] : sel_reg;
    assign ch       = sel_next[2:1];

    // Decode one port write.
    always_comb begin
        tone_period_next  = tone_period_reg;
        atl_next          = atl_reg;
        atr_next          = atr_reg;
        noise_period_next = noise_period_reg;
        rate_next         = rate_reg;
        white_next        = white_reg;
        lfsr_load         = 1'b0;
        if (wr_en) begin
            if (sel_next[0]) begin
                if (wr_right) begin
                    atr_next[ch] = wr_data[3:0];
                end else begin
                    atl_next[ch] = wr_data[3:0];
                end
            end else if (!wr_right) begin
                // Left port pitch writes; the noise channel has none here.
                if (ch != spsg_pkg::CH_NOISE) begin
                    if (latch) begin
                        tone_period_next[ch[1:0]] = {tone_period_reg[ch[1:0]][9:4],
                                                     wr_data[3:0]};
                    end else begin
                        tone_period_next[ch[1:0]] = {wr_data[5:0],
                                                     tone_period_reg[ch[1:0]][3:0]};
                    end
                end
            end else if (latch) begin
                if (ch == spsg_pkg::CH_TONE_C) begin
                    noise_period_next = {noise_period_reg[9:4], wr_data[3:0]};
                end else if (ch == spsg_pkg::CH_NOISE) begin
                    rate_next  = wr_data[1:0];
                    white_next = wr_data[2];
                    lfsr_load  = 1'b1;
                end
            end else if (ch == spsg_pkg::CH_TONE_C) begin
                noise_period_next = {wr_data[5:0], noise_period_reg[3:0]};
            end
        end
    end

    // Register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg          <= '0;
            tone_period_reg  <= '0;
            atl_reg          <= '0;
            atr_reg          <= '0;
            noise_period_reg <= '0;
            rate_reg         <= '0;
            white_reg        <= 1'b0;
        end else begin
            sel_reg          <= sel_next;
            tone_period_reg  <= tone_period_next;
            atl_reg          <= atl_next;
            atr_reg          <= atr_next;
            noise_period_reg <= noise_period_next;
            rate_reg         <= rate_next;
            white_reg        <= white_next;
        end
    end

    assign cfg.tone_period    = tone_period_reg;
    assign cfg.noise_period   = noise_period_reg;
    assign cfg.noise_rate_sel = rate_reg;
    assign cfg.white_mode     = white_reg;
    assign cfg.lfsr_load      = lfsr_load;
    assign atten_left         = atl_reg;
    assign atten_right        = atr_reg;

endmodule

`default_nettype wire

### design/spsg_gen.sv
// Tone dividers, noise divider and noise shift register.
// Depends on spsg_pkg and on the settings from spsg_regs.
`default_nettype none

module spsg_gen (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              tick,
    input  wire spsg_pkg::spsg_cfg_t               cfg,
    output logic [spsg_pkg::NUM_CHAN-1:0]          level_next
);

    logic [spsg_pkg::NUM_TONE-1:0][spsg_pkg::PITCH_W-1:0] tcnt_reg, tcnt_next;
    logic [spsg_pkg::NUM_TONE-1:0]                         tlvl_reg, tlvl_next;
    logic [spsg_pkg::PITCH_W-1:0]                          ncnt_reg, ncnt_next;
    logic                                                  half_reg, half_next;
    logic                                                  nlvl_reg, nlvl_next;
    logic [spsg_pkg::LFSR_W-1:0]                           lfsr_reg, lfsr_next;
    logic [spsg_pkg::PITCH_W-1:0]                          reload;

    // Tone dividers: reload and toggle at zero, else count down.
    always_comb begin
        tcnt_next = tcnt_reg;
        tlvl_next = tlvl_reg;
        for (int i = 0; i < spsg_pkg::NUM_TONE; i++) begin
            if (tick) begin
                if (tcnt_reg[i] == '0) begin
                    tcnt_next[i] = cfg.tone_period[i];
                    tlvl_next[i] = ~tlvl_reg[i];
                end else begin
                    tcnt_next[i] = tcnt_reg[i] - 1'b1;
                end
            end
        end
    end

    // Noise divider reload value.
    always_comb begin
        case (cfg.noise_rate_sel)
            spsg_pkg::RATE_FAST: reload = spsg_pkg::NOISE_RELOAD_0;
            spsg_pkg::RATE_MID:  reload = spsg_pkg::NOISE_RELOAD_1;
            spsg_pkg::RATE_SLOW: reload = spsg_pkg::NOISE_RELOAD_2;
            default:             reload = cfg.noise_period;
        endcase
    end

    // Noise: the shift register steps on every second divider reload.
    always_comb begin
        ncnt_next = ncnt_reg;
        half_next = half_reg;
        nlvl_next = nlvl_reg;
        lfsr_next = lfsr_reg;
        if (cfg.lfsr_load) begin
            lfsr_next = spsg_pkg::LFSR_SEED;
        end else if (tick) begin
            if (ncnt_reg == '0) begin
                ncnt_next = reload;
                half_next = ~half_reg;
                if (!half_reg) begin
                    nlvl_next = ~lfsr_reg[0];
                    lfsr_next = {lfsr_reg[0] ^ (lfsr_reg[2] & cfg.white_mode),
                                 lfsr_reg[spsg_pkg::LFSR_W-1:1]};
                end
            end else begin
                ncnt_next = ncnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tcnt_reg <= '0;
            tlvl_reg <= '0;
            ncnt_reg <= '0;
            half_reg <= 1'b0;
            nlvl_reg <= 1'b0;
            lfsr_reg <= '0;
        end else begin
            tcnt_reg <= tcnt_next;
            tlvl_reg <= tlvl_next;
            ncnt_reg <= ncnt_next;
            half_reg <= half_next;
            nlvl_reg <= nlvl_next;
            lfsr_reg <= lfsr_next;
        end
    end

    // Levels as they stand after this cycle's update.
    assign level_next = {nlvl_next, tlvl_next};

endmodule

`default_nettype wire

### design/stereo_psg_tone_noise_core.sv
// Top level of the stereo tone and noise sound generator: input register,
// result register and stream handshakes. Depends on spsg_pkg, spsg_regs, spsg_gen.
//
// Each input word is a tick or a byte written to the left or right port,
// selected by s_tuser. A tick gives one result word of eight attenuations,
// a write gives none. One word is taken per clock cycle without gaps while
// the result side keeps up. A tick passes through the input register and
// then the result register, whose output drives m_tdata. A tick held in
// the input register behind a stalled result word holds off the input
// side until that word is taken; writes move on regardless. The whole
// update of the dividers, the shift register and the register file for a
// word happens between those two registers.
`default_nettype none

module stereo_psg_tone_noise_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte [7:0]
    input  wire logic [1:0]  s_tuser,   // operation [1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // left_tone_a, left_tone_b, left_tone_c,
                                        // left_noise, right_tone_a, right_tone_b,
                                        // right_tone_c, right_noise (4 bits each)
);

    logic                                               in_valid_reg;
    logic [spsg_pkg::OP_W-1:0]                          in_op_reg;
    logic [spsg_pkg::BYTE_W-1:0]                        in_data_reg;
    logic                                               out_valid_reg;
    logic [31:0]                                        out_data_reg, out_data_next;
    logic                                               out_free;
    logic                                               advance;
    logic                                               is_tick;
    logic                                               is_write;
    spsg_pkg::spsg_cfg_t                                cfg;
    logic [spsg_pkg::NUM_CHAN-1:0][spsg_pkg::ATTEN_W-1:0] atten_left;
    logic [spsg_pkg::NUM_CHAN-1:0][spsg_pkg::ATTEN_W-1:0] atten_right;
    logic [spsg_pkg::NUM_CHAN-1:0]                      level_next;

    // Handshake: the held word moves on unless it is a tick whose result has no room.
    assign is_tick  = in_valid_reg && (in_op_reg == spsg_pkg::OP_TICK);
    assign is_write = in_valid_reg &&
                      ((in_op_reg == spsg_pkg::OP_LEFT) || (in_op_reg == spsg_pkg::OP_RIGHT));
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (out_free || !is_tick);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= s_tuser;
            in_data_reg <= s_tdata;
        end
    end

    spsg_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr_en       (advance && is_write),
        .wr_right    (in_op_reg == spsg_pkg::OP_RIGHT),
        .wr_data     (in_data_reg),
        .cfg         (cfg),
        .atten_left  (atten_left),
        .atten_right (atten_right)
    );

    spsg_gen u_gen (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick       (advance && is_tick),
        .cfg        (cfg),
        .level_next (level_next)
    );

    // A low channel reads as full attenuation.
    always_comb begin
        for (int i = 0; i < spsg_pkg::NUM_CHAN; i++) begin
            out_data_next[i*4 +: 4]      = level_next[i] ? atten_left[i] : spsg_pkg::ATTEN_OFF;
            out_data_next[16 + i*4 +: 4] = level_next[i] ? atten_right[i] : spsg_pkg::ATTEN_OFF;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && is_tick) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && is_tick) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

### design/spsg_checker.sv
// Port-level checks for the stereo tone and noise sound generator, bound to
// the top level. Depends on stereo_psg_tone_noise_core and spsg_pkg.
`default_nettype none

module spsg_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // A stalled result word holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // The input side is never held off while the result side has room.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled although result side is free");

    // A fresh result word follows a tick accepted on the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |->
            $past(s_tvalid && s_tready && (s_tuser == spsg_pkg::OP_TICK), 2))
        else $error("result word without an accepted tick");

endmodule

bind stereo_psg_tone_noise_core spsg_checker u_spsg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### bench/spsg_tb_pkg.sv
`timescale 1ns / 100ps
// Checking side of the stereo tone and noise generator bench: a model of the
// dividers, noise shift register and attenuation registers, and the queue of level words.
// Depends on spsg_pkg for widths, operation codes and reload constants.

package spsg_tb_pkg;
    import spsg_pkg::*;

    // Codes the design package does not name.
    localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
    localparam logic [1:0]        CH_TONE_A = 2'd0;
    localparam logic [1:0]        CH_TONE_B = 2'd1;

    // One result word as it sits on m_tdata, left_tone_a in the lowest bits.
    typedef struct packed {
        logic [ATTEN_W-1:0] right_noise;
        logic [ATTEN_W-1:0] right_tone_c;
        logic [ATTEN_W-1:0] right_tone_b;
        logic [ATTEN_W-1:0] right_tone_a;
        logic [ATTEN_W-1:0] left_noise;
        logic [ATTEN_W-1:0] left_tone_c;
        logic [ATTEN_W-1:0] left_tone_b;
        logic [ATTEN_W-1:0] left_tone_a;
    } psg_levels_t;

    class psg_level_scoreboard;
        logic [SEL_W-1:0]   sel;
        logic [PITCH_W-1:0] tone_period [NUM_TONE];
        logic [PITCH_W-1:0] tone_count  [NUM_TONE];
        logic               tone_level  [NUM_TONE];
        logic [ATTEN_W-1:0] atten_left  [NUM_CHAN];
        logic [ATTEN_W-1:0] atten_right [NUM_CHAN];
        logic [PITCH_W-1:0] noise_period;
        logic [PITCH_W-1:0] noise_count;
        logic [RATE_W-1:0]  noise_rate;
        logic               white_mode;
        logic               half_toggle;
        logic               noise_level;
        logic [LFSR_W-1:0]  noise_shift;
        psg_levels_t        expected_levels [$];
        int                 errors;

        function new();
            errors = 0;
            sel = '0;
            noise_period = '0;
            noise_count = '0;
            noise_rate = '0;
            white_mode = 1'b0;
            half_toggle = 1'b0;
            noise_level = 1'b0;
            noise_shift = '0;
            for (int i = 0; i < NUM_TONE; i++) begin
                tone_period[i] = '0;
                tone_count[i] = '0;
                tone_level[i] = 1'b0;
            end
            for (int i = 0; i < NUM_CHAN; i++) begin
                atten_left[i] = '0;
                atten_right[i] = '0;
            end
        endfunction

        function int outstanding();
            return expected_levels.size();
        endfunction

        // A byte with bit 7 set latches the register select first.
        function void apply_port_byte(bit right, logic [BYTE_W-1:0] d);
            logic [1:0] ch;
            if (d[7]) sel = d[6:4];
            ch = sel[2:1];
            if (sel[0]) begin
                if (right) atten_right[ch] = d[3:0];
                else atten_left[ch] = d[3:0];
            end else if (!right) begin
                // Left port sets tone pitches; the noise slot is ignored.
                if (ch != CH_NOISE) begin
                    if (d[7]) tone_period[ch][3:0] = d[3:0];
                    else tone_period[ch][9:4] = d[5:0];
                end
            end else if (d[7]) begin
                if (ch == CH_TONE_C) begin
                    noise_period[3:0] = d[3:0];
                end else if (ch == CH_NOISE) begin
                    noise_rate = d[1:0];
                    white_mode = d[2];
                    noise_shift = LFSR_SEED;
                end
            end else if (ch == CH_TONE_C) begin
                noise_period[9:4] = d[5:0];
            end
        endfunction

        // One tick: count every divider down and step the noise on every second reload.
        function void advance_dividers();
            logic b0;
            for (int i = 0; i < NUM_TONE; i++) begin
                if (tone_count[i] == '0) begin
                    tone_count[i] = tone_period[i];
                    tone_level[i] = ~tone_level[i];
                end else begin
                    tone_count[i] = tone_count[i] - 1'b1;
                end
            end
            if (noise_count == '0) begin
                case (noise_rate)
                    RATE_FAST: noise_count = NOISE_RELOAD_0;
                    RATE_MID:  noise_count = NOISE_RELOAD_1;
                    RATE_SLOW: noise_count = NOISE_RELOAD_2;
                    default:   noise_count = noise_period;
                endcase
                half_toggle = ~half_toggle;
                if (half_toggle) begin
                    b0 = noise_shift[0];
                    noise_level = ~b0;
                    noise_shift = {b0 ^ (noise_shift[2] & white_mode), noise_shift[LFSR_W-1:1]};
                end
            end else begin
                noise_count = noise_count - 1'b1;
            end
        endfunction

        // Called for every accepted input word.
        function void note_word(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data);
            psg_levels_t lv;
            if (op == OP_LEFT) begin
                apply_port_byte(1'b0, data);
            end else if (op == OP_RIGHT) begin
                apply_port_byte(1'b1, data);
            end else if (op == OP_TICK) begin
                advance_dividers();
                lv.left_tone_a  = tone_level[0] ? atten_left[0]  : ATTEN_OFF;
                lv.left_tone_b  = tone_level[1] ? atten_left[1]  : ATTEN_OFF;
                lv.left_tone_c  = tone_level[2] ? atten_left[2]  : ATTEN_OFF;
                lv.left_noise   = noise_level   ? atten_left[3]  : ATTEN_OFF;
                lv.right_tone_a = tone_level[0] ? atten_right[0] : ATTEN_OFF;
                lv.right_tone_b = tone_level[1] ? atten_right[1] : ATTEN_OFF;
                lv.right_tone_c = tone_level[2] ? atten_right[2] : ATTEN_OFF;
                lv.right_noise  = noise_level   ? atten_right[3] : ATTEN_OFF;
                expected_levels.push_back(lv);
            end
        endfunction

        function void check_field(string name, logic [ATTEN_W-1:0] want,
                                  logic [ATTEN_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // Called for every accepted result word.
        function void check_word(logic [31:0] word);
            psg_levels_t want;
            psg_levels_t got;
            got = word;
            if (expected_levels.size() == 0) begin
                $error("result word %h arrived with no tick waiting", word);
                errors++;
                return;
            end
            want = expected_levels.pop_front();
            check_field("left_tone_a",  want.left_tone_a,  got.left_tone_a);
            check_field("left_tone_b",  want.left_tone_b,  got.left_tone_b);
            check_field("left_tone_c",  want.left_tone_c,  got.left_tone_c);
            check_field("left_noise",   want.left_noise,   got.left_noise);
            check_field("right_tone_a", want.right_tone_a, got.right_tone_a);
            check_field("right_tone_b", want.right_tone_b, got.right_tone_b);
            check_field("right_tone_c", want.right_tone_c, got.right_tone_c);
            check_field("right_noise",  want.right_noise,  got.right_noise);
        endfunction
    endclass

endpackage

### bench/tb_top.sv
`timescale 1ns / 100ps
// Top of the stereo tone and noise generator bench: clock, reset, stimulus and
// result handshakes around stereo_psg_tone_noise_core. Depends on spsg_pkg and spsg_tb_pkg.

module tb_top;
    import spsg_pkg::*;
    import spsg_tb_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_WORDS = 450;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata;
    logic [OP_W-1:0]     s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [31:0]         m_tdata;

    psg_level_scoreboard sb;
    int                  words_sent;
    int                  cycle_count;
    bit                  tx_quiet;
    bit                  rx_quiet;
    int                  rx_stall_left;
    int                  rx_phase_left;

    stereo_psg_tone_noise_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running 20 ns clock.
    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Watchdog: a run that never drains is a failure.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("stereo_psg_tone_noise_core test failed");
        $finish;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int random_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Pitch high bits stay small most of the time so that tones toggle often.
    function automatic logic [5:0] short_pitch_high();
        if ($urandom_range(0, 9) == 0) return 6'($urandom);
        return 6'($urandom_range(0, 1));
    endfunction

    // Result side: stall in random bursts, with quiet stretches in between.
    always @(posedge aclk) begin
        if (rx_phase_left == 0) begin
            rx_phase_left = $urandom_range(40, 300);
            rx_quiet = ($urandom_range(0, 2) == 0);
        end else begin
            rx_phase_left--;
        end
        if (rx_stall_left != 0) begin
            rx_stall_left--;
            m_tready <= 1'b0;
        end else if (!rx_quiet && $urandom_range(0, 99) < 25) begin
            rx_stall_left = random_pause();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Every accepted result word goes straight to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata);
    end

    // Offer one word and hold it until the block takes it.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data);
        int gap;
        if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : random_pause();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_word(op, data);
        words_sent++;
    endtask

    // Stop sending until every tick has been answered.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.outstanding() != 0);
    endtask

    // One random phrase: mostly ticks and well-formed register writes, some noise.
    task automatic send_random_phrase();
        logic [OP_W-1:0] port;
        logic [1:0]      ch;
        int              r;
        r = $urandom_range(0, 99);
        port = $urandom_range(0, 1) ? OP_RIGHT : OP_LEFT;
        ch = 2'($urandom);
        if (r < 55) begin
            repeat ($urandom_range(1, 8)) send_word(OP_TICK, 8'($urandom));
        end else if (r < 70) begin
            // Attenuation, sometimes rewritten by a data byte on the same select.
            send_word(port, {1'b1, ch, 1'b1, 4'($urandom)});
            if ($urandom_range(0, 3) == 0) send_word(port, {1'b0, 3'($urandom), 4'($urandom)});
        end else if (r < 82) begin
            send_word(OP_LEFT, {1'b1, ch, 1'b0, 4'($urandom)});
            send_word(OP_LEFT, {1'b0, 1'($urandom), short_pitch_high()});
        end else if (r < 87) begin
            send_word(OP_RIGHT, {1'b1, CH_TONE_C, 1'b0, 4'($urandom)});
            send_word(OP_RIGHT, {1'b0, 1'($urandom), short_pitch_high()});
        end else if (r < 93) begin
            // Noise control: rate, feedback mode and a fresh seed.
            send_word(OP_RIGHT, {1'b1, CH_NOISE, 1'b0, 4'($urandom)});
        end else begin
            send_word(2'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        int phrase;
        int target;
        sb = new();
        words_sent = 0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        rx_stall_left = 0;
        rx_phase_left = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_TICK;
        m_tready = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Ticks straight after reset: the shift register is still zero.
        send_word(OP_TICK, 8'hFF);
        send_word(OP_UNUSED, 8'hFF);
        send_word(OP_TICK, 8'h00);
        // Attenuations on both sides, the left ones at the extremes, then a data byte reuse.
        send_word(OP_LEFT, 8'h90);
        send_word(OP_LEFT, 8'hBF);
        send_word(OP_RIGHT, 8'hD5);
        send_word(OP_RIGHT, 8'hFA);
        send_word(OP_LEFT, 8'h0C);
        send_word(OP_TICK, 8'h00);
        // Tone pitches: largest period, then back down; the noise slot is ignored.
        send_word(OP_LEFT, 8'h8F);
        send_word(OP_LEFT, 8'h3F);
        send_word(OP_LEFT, 8'h00);
        send_word(OP_LEFT, 8'hA0);
        send_word(OP_LEFT, 8'hC1);
        send_word(OP_LEFT, 8'hE7);
        // Right port pitch writes to tone A change nothing.
        send_word(OP_RIGHT, 8'h83);
        send_word(OP_RIGHT, 8'h40);
        // Noise period, high bits at the top and then cleared.
        send_word(OP_RIGHT, 8'hC2);
        send_word(OP_RIGHT, 8'h3F);
        send_word(OP_RIGHT, 8'h00);
        // White noise from the programmed period, then periodic at the fast rate.
        send_word(OP_RIGHT, 8'hE7);
        repeat (3) send_word(OP_TICK, 8'h55);
        send_word(OP_RIGHT, 8'hE0);
        send_word(OP_TICK, 8'hAA);
        wait_drained();

        // Random phrases, draining now and then.
        target = words_sent + RANDOM_WORDS;
        phrase = 0;
        while (words_sent < target) begin
            send_random_phrase();
            phrase++;
            if (phrase % 120 == 0) wait_drained();
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("stereo_psg_tone_noise_core test passed");
        end else begin
            $display("stereo_psg_tone_noise_core test failed");
        end
        $finish;
    end

endmodule

### sim.f
design/spsg_pkg.sv
design/spsg_regs.sv
design/spsg_gen.sv
design/stereo_psg_tone_noise_core.sv
design/spsg_checker.sv
bench/spsg_tb_pkg.sv
bench/tb_top.sv
